// ===== rtl/cdsw_pkg.sv =====
// ----------------------------------------------------------------------------
// cdsw_pkg
// shared types and constants of the concentric disk sample warp
// ----------------------------------------------------------------------------
package cdsw_pkg;

  localparam int unsigned AngFrac = 30;
  localparam int unsigned QW      = AngFrac + 1;   // ratio width, q <= 2^30
  localparam int unsigned RW      = 34;            // widest signed radius
  localparam int unsigned XW      = 33;            // cordic x / y width
  localparam int unsigned ZW      = 32;            // cordic angle width

  localparam logic [29:0]          Pi4Q30  = 30'd843314856;
  localparam logic signed [XW-1:0] GainQ30 = 33'sd652032874;
  localparam logic [15:0]          OutLimit = 16'd32767;

  // per-word sideband carried along the pipe
  typedef struct packed {
    logic signed [RW-1:0] r;      // signed radius
    logic                 horiz;  // horizontal sector
    logic                 neg;    // sin takes negative sign
    logic                 zero;   // exact origin
  } side_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int unsigned idx);
    logic [31:0] v;
    begin
      unique case (idx)
        0:  v = 32'h3243F6A8;
        1:  v = 32'h1DAC6705;
        2:  v = 32'h0FADBAFC;
        3:  v = 32'h07F56EA6;
        4:  v = 32'h03FEAB76;
        5:  v = 32'h01FFD55B;
        6:  v = 32'h00FFFAAA;
        7:  v = 32'h007FFF55;
        8:  v = 32'h003FFFEA;
        9:  v = 32'h001FFFFD;
        10: v = 32'h000FFFFF;
        11: v = 32'h0007FFFF;
        12: v = 32'h0003FFFF;
        13: v = 32'h0001FFFF;
        14: v = 32'h0000FFFF;
        15: v = 32'h00007FFF;
        16: v = 32'h00003FFF;
        17: v = 32'h00001FFF;
        18: v = 32'h00000FFF;
        19: v = 32'h000007FF;
        20: v = 32'h000003FF;
        21: v = 32'h000001FF;
        22: v = 32'h000000FF;
        23: v = 32'h0000007F;
        24: v = 32'h0000003F;
        25: v = 32'h0000001F;
        26: v = 32'h0000000F;
        27: v = 32'h00000007;
        28: v = 32'h00000003;
        29: v = 32'h00000001;
        default: v = 32'h00000000;
      endcase
      return $signed(v);
    end
  endfunction

endpackage

// ===== rtl/concentric_disk_sample_warp.sv =====
// ----------------------------------------------------------------------------
// concentric_disk_sample_warp
// square-to-disk concentric mapping in a chain of fixed-point cells
// ----------------------------------------------------------------------------
// usage:
//   input word (u_first_i, u_second_i) is taken when valid_i is high and
//   stall_o is low; output word (disk_x_o, disk_y_o) leaves when valid_o is
//   high and stall_i is low. one output word per input word, in order.
// throughput: one word per cycle unless stall_i holds the output word, every cell holds one word in flight.
// chain: front-end register, the 31 divider cells (one quotient bit each), the
//   angle product and angle registers, the cordic cells (one rotation each),
//   then the sector swap, product and output registers.
// reset: clears every valid bit, the pipe comes up empty.
// stall: when the output word is held by stall_i the whole chain freezes
//   and stall_o rises in the same cycle; bubbles inside the chain freeze too.
// ----------------------------------------------------------------------------
module concentric_disk_sample_warp
  import cdsw_pkg::*;
#(
  parameter int unsigned IN_FRAC_BITS   = 16,
  parameter int unsigned OUT_FRAC_BITS  = 15,
  parameter int unsigned ROTATION_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic        [15:0] u_first_i,
  input  logic        [15:0] u_second_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [15:0] disk_x_o,
  output logic signed [15:0] disk_y_o
);

  localparam int unsigned OW = IN_FRAC_BITS + 2;               // offset width
  localparam int unsigned UW = (IN_FRAC_BITS < 16) ? IN_FRAC_BITS : 16;
  localparam int unsigned NS = ROTATION_STEPS;
  localparam int unsigned PW = OW + XW;                        // product width
  localparam int unsigned SH = IN_FRAC_BITS + AngFrac - OUT_FRAC_BITS;

  // the whole chain moves unless the output word is held
  logic adv;
  assign adv     = !(valid_o && stall_i);
  assign stall_o = !adv;

  // ---------------- front end: offsets, magnitudes, sector ----------------
  logic        [OW-1:0] ux, uy;
  logic signed [OW-1:0] ox, oy;
  logic        [OW-1:0] ax, ay;
  logic                 horiz;
  side_t                side_d;

  always_comb begin
    ux = OW'(u_first_i[UW-1:0]);
    uy = OW'(u_second_i[UW-1:0]);
    ox = $signed({ux[OW-2:0], 1'b0} - (OW'(1) << IN_FRAC_BITS));
    oy = $signed({uy[OW-2:0], 1'b0} - (OW'(1) << IN_FRAC_BITS));
    ax = ox[OW-1] ? OW'(-ox) : OW'(ox);
    ay = oy[OW-1] ? OW'(-oy) : OW'(oy);
    horiz        = ax > ay;
    side_d.r     = horiz ? RW'(ox) : RW'(oy);
    side_d.horiz = horiz;
    side_d.neg   = ox[OW-1] != oy[OW-1];
    side_d.zero  = (ox == '0) && (oy == '0);
  end

  // divider chain taps, index 0 is the front-end register
  logic              dv_v   [QW+1];
  logic [OW-1:0]     dv_rem [QW+1];
  logic [OW-1:0]     dv_lg  [QW+1];
  logic [QW-1:0]     dv_q   [QW+1];
  side_t             dv_sd  [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_rem[0] <= horiz ? ay : ax;   // smaller magnitude
      dv_lg[0]  <= horiz ? ax : ay;   // larger magnitude
      dv_q[0]   <= '0;
      dv_sd[0]  <= side_d;
    end
  end

  // ---------------- ratio: one quotient bit per cell ----------------
  for (genvar k = 0; k < QW; k++) begin : g_div
    cdsw_div_cell #(
      .W    (OW),
      .BIT  (QW - 1 - k),
      .FIRST(k == 0)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(dv_v[k]),
      .rem_i  (dv_rem[k]),
      .lg_i   (dv_lg[k]),
      .q_i    (dv_q[k]),
      .side_i (dv_sd[k]),
      .valid_o(dv_v[k+1]),
      .rem_o  (dv_rem[k+1]),
      .lg_o   (dv_lg[k+1]),
      .q_o    (dv_q[k+1]),
      .side_o (dv_sd[k+1])
    );
  end

  // ---------------- angle = q * pi/4, split into two partial products ------
  logic        am_v_q, aa_v_q;
  logic [45:0] plo_q;
  logic [44:0] phi_q;
  side_t       am_sd_q;
  logic [61:0] asum;
  logic [29:0] ang;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      am_v_q <= 1'b0;
      aa_v_q <= 1'b0;
    end else if (adv) begin
      am_v_q <= dv_v[QW];
      aa_v_q <= am_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      plo_q   <= 46'(dv_q[QW][15:0]) * 46'(Pi4Q30);
      phi_q   <= 45'(dv_q[QW][QW-1:16]) * 45'(Pi4Q30);
      am_sd_q <= dv_sd[QW];
    end
  end

  assign asum = (62'(phi_q) << 16) + 62'(plo_q);
  assign ang  = asum[59:30];

  // cordic chain taps, index 0 is the angle register
  logic                 rt_v  [NS+1];
  logic signed [XW-1:0] rt_x  [NS+1];
  logic signed [XW-1:0] rt_y  [NS+1];
  logic signed [ZW-1:0] rt_z  [NS+1];
  side_t                rt_sd [NS+1];

  assign rt_v[0] = aa_v_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rt_x[0]  <= GainQ30;
      rt_y[0]  <= '0;
      rt_z[0]  <= $signed(ZW'(ang));
      rt_sd[0] <= am_sd_q;
    end
  end

  // ---------------- cos / sin: one rotation per cell ----------------
  for (genvar i = 0; i < NS; i++) begin : g_rot
    cdsw_rot_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(rt_v[i]),
      .x_i    (rt_x[i]),
      .y_i    (rt_y[i]),
      .z_i    (rt_z[i]),
      .side_i (rt_sd[i]),
      .valid_o(rt_v[i+1]),
      .x_o    (rt_x[i+1]),
      .y_o    (rt_y[i+1]),
      .z_o    (rt_z[i+1]),
      .side_o (rt_sd[i+1])
    );
  end

  // ---------------- sector swap, sin sign ----------------
  logic                 sl_v_q, mu_v_q;
  logic signed [XW-1:0] tx_q, ty_q;
  logic signed [OW-1:0] r_q;
  logic                 z_q, z2_q;
  logic signed [XW-1:0] sn;
  logic signed [PW-1:0] px_q, py_q;

  assign sn = rt_sd[NS].neg ? -rt_y[NS] : rt_y[NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sl_v_q <= 1'b0;
      mu_v_q <= 1'b0;
    end else if (adv) begin
      sl_v_q <= rt_v[NS];
      mu_v_q <= sl_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tx_q <= rt_sd[NS].horiz ? rt_x[NS] : sn;
      ty_q <= rt_sd[NS].horiz ? sn : rt_x[NS];
      r_q  <= OW'(rt_sd[NS].r);
      z_q  <= rt_sd[NS].zero;
      // radius times trig
      px_q <= PW'(r_q) * PW'(tx_q);
      py_q <= PW'(r_q) * PW'(ty_q);
      z2_q <= z_q;
    end
  end

  // ---------------- round half away from zero, saturate ----------------
  function automatic logic [15:0] scale_out(input logic signed [PW-1:0] p);
    logic          neg;
    logic [PW:0]   m;
    logic [PW:0]   mr;
    logic [15:0]   mag;
    begin
      neg = p[PW-1];
      m   = neg ? (PW+1)'(-$signed({p[PW-1], p})) : (PW+1)'(p);
      mr  = (m + ((PW+1)'(1) << (SH - 1))) >> SH;
      mag = (mr > (PW+1)'(OutLimit)) ? OutLimit : mr[15:0];
      return neg ? 16'(-mag) : mag;
    end
  endfunction

  logic out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= mu_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      disk_x_o <= z2_q ? '0 : $signed(scale_out(px_q));
      disk_y_o <= z2_q ? '0 : $signed(scale_out(py_q));
    end
  end

  assign valid_o = out_v_q;

  // ---------------- checks ----------------
  a_x_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> disk_x_o != 16'sh8000)
    else $error("disk_x out of saturation range");

  a_y_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> disk_y_o != 16'sh8000)
    else $error("disk_y out of saturation range");

  a_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && mu_v_q && z2_q) |=> (disk_x_o == '0 && disk_y_o == '0))
    else $error("origin word not zero");

  a_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o)
    else $error("chain frozen without output word");

endmodule

// ===== rtl/cdsw_div_cell.sv =====
// ----------------------------------------------------------------------------
// cdsw_div_cell
// one restoring division cell, settles one quotient bit
// ----------------------------------------------------------------------------
module cdsw_div_cell
  import cdsw_pkg::*;
#(
  parameter int unsigned W     = 18,
  parameter int unsigned BIT   = 30,
  parameter bit          FIRST = 1'b0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [W-1:0]  rem_i,
  input  logic [W-1:0]  lg_i,
  input  logic [QW-1:0] q_i,
  input  side_t         side_i,
  output logic          valid_o,
  output logic [W-1:0]  rem_o,
  output logic [W-1:0]  lg_o,
  output logic [QW-1:0] q_o,
  output side_t         side_o
);

  logic [W-1:0]  rem_sh, rem_d;
  logic [QW-1:0] q_d;
  logic          ge;

  always_comb begin
    rem_sh = FIRST ? rem_i : {rem_i[W-2:0], 1'b0};
    ge     = rem_sh >= lg_i;
    rem_d  = ge ? rem_sh - lg_i : rem_sh;
    q_d    = q_i;
    q_d[BIT] = ge;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      lg_o   <= lg_i;
      q_o    <= q_d;
      side_o <= side_i;
    end
  end

endmodule

// ===== rtl/cdsw_rot_cell.sv =====
// ----------------------------------------------------------------------------
// cdsw_rot_cell
// one cordic rotation cell with a fixed shift
// ----------------------------------------------------------------------------
module cdsw_rot_cell
  import cdsw_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  side_t                side_i,
  output logic                 valid_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output side_t                side_o
);

  localparam logic signed [ZW-1:0] Atan = atan_q30(IDX);

  logic signed [XW-1:0] dx, dy, x_d, y_d;
  logic signed [ZW-1:0] z_d;

  always_comb begin
    dx = y_i >>> IDX;
    dy = x_i >>> IDX;
    if (!z_i[ZW-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - Atan;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= x_d;
      y_o    <= y_d;
      z_o    <= z_d;
      side_o <= side_i;
    end
  end

endmodule
